// ===== rtl/core/single_precision_gemm_core_macros.svh =====
// Assertion helpers for the GEMM core.
`ifndef SINGLE_PRECISION_GEMM_CORE_MACROS_SVH
`define SINGLE_PRECISION_GEMM_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SGC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgemm core check failed");

// Next-cycle implication.
`define SGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgemm core check failed");

`endif

// ===== rtl/core/sgemm_pkg.sv =====
package sgemm_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [2:0] CMD_LOAD_A = 3'd0;
    localparam logic [2:0] CMD_LOAD_B = 3'd1;
    localparam logic [2:0] CMD_LOAD_C = 3'd2;
    localparam logic [2:0] CMD_COMPUTE = 3'd3;
    localparam logic [2:0] CMD_READ_C = 3'd4;

    localparam logic [2:0] CFG_ROWS_M  = 3'd0;
    localparam logic [2:0] CFG_COLS_N  = 3'd1;
    localparam logic [2:0] CFG_INNER_K = 3'd2;
    localparam logic [2:0] CFG_ALPHA   = 3'd3;
    localparam logic [2:0] CFG_BETA    = 3'd4;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    // request into the float unit
    typedef struct packed {
        logic        go;
        logic        op_add;
        logic [31:0] x;
        logic [31:0] y;
    } fpu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] res;
    } fpu_rsp_t;

    function automatic logic [ADDR_W-1:0] addr_of(input int r, input int c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

endpackage

// ===== rtl/core/sgemm_fpu.sv =====
module sgemm_fpu
    import sgemm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_NORM  = 3'b010,
        F_ROUND = 3'b100
    } fstate_t;

    fstate_t            state_reg;
    logic               sign_reg;
    logic signed [10:0] exp_reg;
    logic [48:0]        man_reg;
    logic               st_reg;
    logic               spec_reg;
    logic [31:0]        spec_val_reg;
    logic [31:0]        res_reg;
    logic               done_reg;

    // unpack
    logic               xs, ys;
    logic [7:0]         xe, ye;
    logic [22:0]        xf, yf;
    logic [23:0]        xm, ym;
    logic signed [10:0] xee, yee;
    logic               x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;

    assign xs = req.x[31];
    assign ys = req.y[31];
    assign xe = req.x[30:23];
    assign ye = req.y[30:23];
    assign xf = req.x[22:0];
    assign yf = req.y[22:0];
    assign xm = {xe != 8'd0, xf};
    assign ym = {ye != 8'd0, yf};
    assign xee = (xe == 8'd0) ? 11'sd1 : $signed({3'b000, xe});
    assign yee = (ye == 8'd0) ? 11'sd1 : $signed({3'b000, ye});
    assign x_nan  = (xe == 8'hFF) && (xf != 23'd0);
    assign y_nan  = (ye == 8'hFF) && (yf != 23'd0);
    assign x_inf  = (xe == 8'hFF) && (xf == 23'd0);
    assign y_inf  = (ye == 8'hFF) && (yf == 23'd0);
    assign x_zero = (xe == 8'd0) && (xf == 23'd0);
    assign y_zero = (ye == 8'd0) && (yf == 23'd0);

    // multiply path
    logic [47:0]        prod;
    logic signed [10:0] mul_exp;
    logic               mul_nan, mul_inf;

    assign prod    = xm * ym;
    assign mul_exp = xee + yee - 11'sd126;
    assign mul_nan = x_nan || y_nan || (x_inf && y_zero) || (x_zero && y_inf);
    assign mul_inf = x_inf || y_inf;

    // add path: align the smaller magnitude to the larger
    logic               x_big;
    logic               bs, ss;
    logic [23:0]        bm, sm;
    logic signed [10:0] be, se;
    logic [10:0]        dexp;
    logic [48:0]        big_w, small_w0, small_w, lost_mask, sum_w;
    logic               add_nan, add_inf;
    logic [31:0]        add_inf_val;

    always_comb
    begin
        x_big     = req.x[30:0] >= req.y[30:0];
        bs        = x_big ? xs : ys;
        ss        = x_big ? ys : xs;
        bm        = x_big ? xm : ym;
        sm        = x_big ? ym : xm;
        be        = x_big ? xee : yee;
        se        = x_big ? yee : xee;
        dexp      = 11'(be - se);
        big_w     = {1'b0, bm, 24'd0};
        small_w0  = {1'b0, sm, 24'd0};
        lost_mask = '0;
        if (dexp > 11'd25)
        begin
            small_w = {48'd0, sm != 24'd0};
        end
        else
        begin
            lost_mask = (49'd1 << dexp[4:0]) - 49'd1;
            small_w   = (small_w0 >> dexp[4:0]);
            small_w[0] = small_w[0] | ((small_w0 & lost_mask) != 49'd0);
        end
        sum_w       = (bs == ss) ? (big_w + small_w) : (big_w - small_w);
        add_nan     = x_nan || y_nan || (x_inf && y_inf && (xs != ys));
        add_inf     = x_inf || y_inf;
        add_inf_val = x_inf ? req.x : req.y;
    end

    // rounding, to nearest even
    logic               inc;
    logic [24:0]        rsum;
    logic signed [10:0] exp_r;
    logic [23:0]        mant_r;
    logic [31:0]        res_round;

    always_comb
    begin
        inc    = man_reg[23] && (man_reg[24] || (man_reg[22:0] != 23'd0) || st_reg);
        rsum   = {1'b0, man_reg[47:24]} + {24'd0, inc};
        exp_r  = rsum[24] ? (exp_reg + 11'sd1) : exp_reg;
        mant_r = rsum[24] ? rsum[24:1] : rsum[23:0];
        if (spec_reg)
        begin
            res_round = spec_val_reg;
        end
        else if ((mant_r != 24'd0) && (exp_r >= 11'sd255))
        begin
            res_round = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            res_round = {sign_reg, mant_r[23] ? exp_r[7:0] : 8'h00, mant_r[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (req.go)
                    begin
                        state_reg <= F_NORM;
                    end
                end
                F_NORM:
                begin
                    if ((man_reg == 49'd0) || spec_reg)
                    begin
                        state_reg <= F_ROUND;
                    end
                    else if (man_reg[48])
                    begin
                    end
                    else if (exp_reg < 11'sd1)
                    begin
                    end
                    else if (!man_reg[47] && (exp_reg > 11'sd1))
                    begin
                    end
                    else
                    begin
                        state_reg <= F_ROUND;
                    end
                end
                F_ROUND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (req.go)
                begin
                    st_reg <= 1'b0;
                    if (req.op_add)
                    begin
                        man_reg      <= sum_w;
                        exp_reg      <= be;
                        sign_reg     <= (sum_w == 49'd0) ? (xs && ys) : bs;
                        spec_reg     <= add_nan || add_inf;
                        spec_val_reg <= add_nan ? QNAN_BITS : add_inf_val;
                    end
                    else
                    begin
                        man_reg      <= {1'b0, prod};
                        exp_reg      <= mul_exp;
                        sign_reg     <= xs ^ ys;
                        spec_reg     <= mul_nan || mul_inf;
                        spec_val_reg <= mul_nan ? QNAN_BITS : {xs ^ ys, 8'hFF, 23'd0};
                    end
                end
            end
            F_NORM:
            begin
                if ((man_reg == 49'd0) || spec_reg)
                begin
                end
                else if (man_reg[48])
                begin
                    man_reg <= man_reg >> 1;
                    st_reg  <= st_reg | man_reg[0];
                    exp_reg <= exp_reg + 11'sd1;
                end
                else if (exp_reg < 11'sd1)
                begin
                    // drop towards the subnormal range, collecting sticky bits
                    if (exp_reg < -11'sd7)
                    begin
                        man_reg <= man_reg >> 8;
                        st_reg  <= st_reg | (man_reg[7:0] != 8'd0);
                        exp_reg <= exp_reg + 11'sd8;
                    end
                    else
                    begin
                        man_reg <= man_reg >> 1;
                        st_reg  <= st_reg | man_reg[0];
                        exp_reg <= exp_reg + 11'sd1;
                    end
                end
                else if (!man_reg[47] && (exp_reg > 11'sd1))
                begin
                    if ((man_reg[47:40] == 8'd0) && (exp_reg > 11'sd8))
                    begin
                        man_reg <= man_reg << 8;
                        exp_reg <= exp_reg - 11'sd8;
                    end
                    else
                    begin
                        man_reg <= man_reg << 1;
                        exp_reg <= exp_reg - 11'sd1;
                    end
                end
                else
                begin
                end
            end
            F_ROUND:
            begin
                res_reg <= res_round;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.busy = (state_reg != F_IDLE);
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ===== rtl/core/single_precision_gemm_core.sv =====
// Single precision GEMM core: C = alpha*A*B + beta*C on stores of 16 by 16
// elements. Issue a request by holding start high while busy is low; load
// requests (cmd 0..2) write one element and leave busy low, so loads may be
// issued back to back. A read of C (cmd 4) first reads the store, then puts
// the result on kind/data with strobe high for one cycle. A compute request
// (cmd 3) first scales the M by N block of C by beta, then walks the
// multiply-adds in row, inner index, column order through one shared float
// unit; every float operation waits for the previous one, and an operation
// takes longer when cancellation or subnormal values need extra normalising
// steps. Compute ends with a done result (kind 0, data 0). Results cannot be
// held off: capture them in the cycle that strobe is high. Write the dimension
// and scale registers only while busy is low and no result is pending.
// Elements never loaded read as undefined.
`include "single_precision_gemm_core_macros.svh"

module single_precision_gemm_core
    import sgemm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [3:0]  row,
    input  logic [3:0]  col,
    input  logic [31:0] value,
    output logic        strobe,
    output logic        kind,
    output logic [31:0] data,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_READ  = 13'b0000000000010,
        S_BRD   = 13'b0000000000100,
        S_BMUL  = 13'b0000000001000,
        S_BWAIT = 13'b0000000010000,
        S_TRD   = 13'b0000000100000,
        S_TMUL  = 13'b0000001000000,
        S_TWAIT = 13'b0000010000000,
        S_PRD   = 13'b0000100000000,
        S_PMUL  = 13'b0001000000000,
        S_PWAIT = 13'b0010000000000,
        S_AADD  = 13'b0100000000000,
        S_AWAIT = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [4:0]  rows_m_reg, cols_n_reg, inner_k_reg;
    logic [31:0] alpha_reg, beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= 5'd16;
            cols_n_reg  <= 5'd16;
            inner_k_reg <= 5'd16;
            alpha_reg   <= 32'h3F80_0000;
            beta_reg    <= 32'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_ROWS_M:  rows_m_reg  <= wr_data[4:0];
                CFG_COLS_N:  cols_n_reg  <= wr_data[4:0];
                CFG_INNER_K: inner_k_reg <= wr_data[4:0];
                CFG_ALPHA:   alpha_reg   <= wr_data;
                CFG_BETA:    beta_reg    <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // dimensions saturate at the store size
    logic [DIM_W-1:0] m_eff, n_eff, k_eff;

    assign m_eff = (int'(rows_m_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_m_reg);
    assign n_eff = (int'(cols_n_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_n_reg);
    assign k_eff = (int'(inner_k_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_k_reg);

    // loop counters
    logic [IDX_W-1:0] i_reg, j_reg, kk_reg;
    logic             i_last, j_last, kk_last;

    assign i_last  = (DIM_W'(i_reg) + DIM_W'(1)) == m_eff;
    assign j_last  = (DIM_W'(j_reg) + DIM_W'(1)) == n_eff;
    assign kk_last = (DIM_W'(kk_reg) + DIM_W'(1)) == k_eff;

    // request decode
    logic              accept;
    logic              in_range;
    logic [ADDR_W-1:0] req_addr;

    assign accept   = start && !busy;
    assign in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign req_addr = addr_of(int'(row), int'(col));

    // float unit
    fpu_req_t fpu_req;
    fpu_rsp_t fpu_rsp;
    logic [31:0] t_reg, prod_reg;

    sgemm_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    // stores and their ports
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];
    logic [31:0] a_q, b_q, c_q;

    logic              a_we, b_we, c_we;
    logic [ADDR_W-1:0] a_raddr, b_raddr, c_raddr, c_waddr;
    logic [31:0]       c_wdata;
    logic              loop_addr;

    assign loop_addr = (state_reg != S_IDLE);
    assign a_we    = accept && (cmd == CMD_LOAD_A) && in_range;
    assign b_we    = accept && (cmd == CMD_LOAD_B) && in_range;
    assign a_raddr = addr_of(int'(i_reg), int'(kk_reg));
    assign b_raddr = addr_of(int'(kk_reg), int'(j_reg));
    assign c_raddr = loop_addr ? addr_of(int'(i_reg), int'(j_reg)) : req_addr;
    assign c_waddr = c_raddr;

    always_comb
    begin
        c_we    = accept && (cmd == CMD_LOAD_C) && in_range;
        c_wdata = value;
        if (((state_reg == S_BWAIT) || (state_reg == S_AWAIT)) && fpu_rsp.done)
        begin
            c_we    = 1'b1;
            c_wdata = fpu_rsp.res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[req_addr] <= value;
        end
        a_q <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[req_addr] <= value;
        end
        b_q <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_q <= c_mem[c_raddr];
    end

    // float unit operands; issue for one cycle in each issue state
    always_comb
    begin
        fpu_req.go     = 1'b0;
        fpu_req.op_add = 1'b0;
        fpu_req.x      = c_q;
        fpu_req.y      = beta_reg;
        unique case (state_reg)
            S_BMUL:
            begin
                fpu_req.go = 1'b1;
            end
            S_TMUL:
            begin
                fpu_req.go = 1'b1;
                fpu_req.x  = alpha_reg;
                fpu_req.y  = a_q;
            end
            S_PMUL:
            begin
                fpu_req.go = 1'b1;
                fpu_req.x  = t_reg;
                fpu_req.y  = b_q;
            end
            S_AADD:
            begin
                fpu_req.go     = 1'b1;
                fpu_req.op_add = 1'b1;
                fpu_req.x      = c_q;
                fpu_req.y      = prod_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_TWAIT) && fpu_rsp.done)
        begin
            t_reg <= fpu_rsp.res;
        end
        if ((state_reg == S_PWAIT) && fpu_rsp.done)
        begin
            prod_reg <= fpu_rsp.res;
        end
    end

    // sequencer and result register
    logic        strobe_reg, kind_reg, rd_range_reg;
    logic [31:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            kk_reg       <= '0;
            strobe_reg   <= 1'b0;
            kind_reg     <= KIND_DONE;
            rd_range_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd == CMD_READ_C))
                    begin
                        rd_range_reg <= in_range;
                        state_reg    <= S_READ;
                    end
                    else if (accept && (cmd == CMD_COMPUTE))
                    begin
                        i_reg  <= '0;
                        j_reg  <= '0;
                        kk_reg <= '0;
                        if ((m_eff == '0) || (n_eff == '0))
                        begin
                            // nothing to touch: report done at once
                            strobe_reg <= 1'b1;
                            kind_reg   <= KIND_DONE;
                        end
                        else
                        begin
                            state_reg <= S_BRD;
                        end
                    end
                end
                S_READ:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg   <= KIND_READ;
                    state_reg  <= S_IDLE;
                end
                S_BRD:   state_reg <= S_BMUL;
                S_BMUL:  state_reg <= S_BWAIT;
                S_BWAIT:
                begin
                    if (fpu_rsp.done)
                    begin
                        if (j_last)
                        begin
                            j_reg <= '0;
                            if (i_last)
                            begin
                                i_reg <= '0;
                                if (k_eff == '0)
                                begin
                                    strobe_reg <= 1'b1;
                                    kind_reg   <= KIND_DONE;
                                    state_reg  <= S_IDLE;
                                end
                                else
                                begin
                                    state_reg <= S_TRD;
                                end
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_BRD;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_BRD;
                        end
                    end
                end
                S_TRD:   state_reg <= S_TMUL;
                S_TMUL:  state_reg <= S_TWAIT;
                S_TWAIT:
                begin
                    if (fpu_rsp.done)
                    begin
                        state_reg <= S_PRD;
                    end
                end
                S_PRD:   state_reg <= S_PMUL;
                S_PMUL:  state_reg <= S_PWAIT;
                S_PWAIT:
                begin
                    if (fpu_rsp.done)
                    begin
                        state_reg <= S_AADD;
                    end
                end
                S_AADD:  state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (fpu_rsp.done)
                    begin
                        if (!j_last)
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_PRD;
                        end
                        else
                        begin
                            j_reg <= '0;
                            if (!kk_last)
                            begin
                                kk_reg    <= kk_reg + 1'b1;
                                state_reg <= S_TRD;
                            end
                            else
                            begin
                                kk_reg <= '0;
                                if (!i_last)
                                begin
                                    i_reg     <= i_reg + 1'b1;
                                    state_reg <= S_TRD;
                                end
                                else
                                begin
                                    i_reg      <= '0;
                                    strobe_reg <= 1'b1;
                                    kind_reg   <= KIND_DONE;
                                    state_reg  <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // read data is captured with the strobe; done carries zero
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            data_reg <= rd_range_reg ? c_q : 32'd0;
        end
        else
        begin
            data_reg <= 32'd0;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign kind   = kind_reg;
    assign data   = data_reg;

    // a result always leaves the sequencer idle
    `SGC_ASSERT_IMPL(a_strobe_idle, strobe, !busy)
    // never issue to the float unit while it is working
    `SGC_ASSERT_IMPL(a_fpu_free, fpu_req.go, !fpu_rsp.busy)
    // an issued operation keeps the unit busy next cycle
    `SGC_ASSERT_NEXT(a_fpu_takes, fpu_req.go, fpu_rsp.busy)
    // a write of C during compute comes only from a finished float result
    `SGC_ASSERT_IMPL(a_seq_write, c_we && busy, fpu_rsp.done)

endmodule

// ===== sim/tb_single_precision_gemm_core.sv =====
module tb_single_precision_gemm_core;
    import sgemm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One request as the sender presents it.
    typedef struct {
        logic [2:0]  op;
        logic [3:0]  r;
        logic [3:0]  c;
        logic [31:0] v;
    } gemm_req_t;

    // One result as the block should strobe it out.
    typedef struct {
        logic        k;
        logic [31:0] d;
    } gemm_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  cmd = '0;
    logic [3:0]  row = '0;
    logic [3:0]  col = '0;
    logic [31:0] value = '0;
    logic        strobe;
    logic        kind;
    logic [31:0] data;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [31:0] wr_data = '0;

    // Requests waiting for the driver, and results the block still owes us.
    gemm_req_t req_q[$];
    gemm_res_t owed_q[$];

    // Shadow copy of the block: element stores and register file.
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];
    logic [4:0]  dim_m = 5'd16;
    logic [4:0]  dim_n = 5'd16;
    logic [4:0]  dim_k = 5'd16;
    logic [31:0] alpha_f = 32'h3F80_0000;
    logic [31:0] beta_f = 32'h0000_0000;

    int idle_pct = 0;
    int n_bad = 0;

    single_precision_gemm_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .row      (row),
        .col      (col),
        .value    (value),
        .strobe   (strobe),
        .kind     (kind),
        .data     (data),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // IEEE single arithmetic, round to nearest even, subnormals kept,
    // every NaN folded onto the canonical quiet pattern.
    // ------------------------------------------------------------------

    // Round m * 2^e into a single bit pattern with sign s.
    function automatic logic [31:0] fp_round_pack(input logic s, input logic [63:0] m,
                                                  input int e);
        int p;
        int sh;
        int bexp;
        logic [127:0] w;
        logic [127:0] kept;
        logic [127:0] rem;
        logic [127:0] half;
        if (m == 64'd0)
            return {s, 31'd0};
        p = 63;
        while (!m[p])
            p--;
        // Keep 24 significant bits, but never go below the subnormal LSB weight.
        sh = p - 23;
        if (sh < -149 - e)
            sh = -149 - e;
        w = {64'd0, m};
        if (sh > 0)
        begin
            if (sh > 127)
                sh = 127;
            kept = w >> sh;
            rem  = w - (kept << sh);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0]))
                kept = kept + 128'd1;
        end
        else
            kept = w << (-sh);
        bexp = e + sh + 150;
        if (kept[24])
        begin
            kept = kept >> 1;
            bexp++;
        end
        if (!kept[23])
            bexp = 0;
        if (bexp >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, 8'(bexp), kept[22:0]};
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 23'd0;
    endfunction

    // Significand with hidden bit and the matching effective exponent.
    function automatic void fp_split(input logic [31:0] x, output logic [63:0] mant,
                                     output int ex);
        if (x[30:23] == 8'd0)
        begin
            mant = {41'd0, x[22:0]};
            ex   = 1;
        end
        else
        begin
            mant = {40'd0, 1'b1, x[22:0]};
            ex   = int'(x[30:23]);
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
        logic        s;
        logic [63:0] mx;
        logic [63:0] my;
        int          ex;
        int          ey;
        s = x[31] ^ y[31];
        if (fp_is_nan(x) || fp_is_nan(y))
            return QNAN_BITS;
        if ((fp_is_inf(x) && y[30:0] == 31'd0) || (fp_is_inf(y) && x[30:0] == 31'd0))
            return QNAN_BITS;
        if (fp_is_inf(x) || fp_is_inf(y))
            return {s, 8'hFF, 23'd0};
        fp_split(x, mx, ex);
        fp_split(y, my, ey);
        return fp_round_pack(s, mx * my, ex + ey - 300);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] t;
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] big;
        logic [63:0] lit;
        logic [63:0] mag;
        logic        s;
        int          ex;
        int          ey;
        int          d;
        if (fp_is_nan(x) || fp_is_nan(y))
            return QNAN_BITS;
        if (fp_is_inf(x) && fp_is_inf(y) && x[31] != y[31])
            return QNAN_BITS;
        if (fp_is_inf(x))
            return x;
        if (fp_is_inf(y))
            return y;
        fp_split(x, mx, ex);
        fp_split(y, my, ey);
        if (ex < ey)
        begin
            t = x; x = y; y = t;
            fp_split(x, mx, ex);
            fp_split(y, my, ey);
        end
        // 39 guard bits; anything shifted further out folds into a sticky LSB.
        d   = ex - ey;
        big = mx << 39;
        lit = my << 39;
        if (d >= 64)
            lit = {63'd0, lit != 64'd0};
        else if (d > 0)
            lit = (lit >> d) | {63'd0, (lit & ((64'd1 << d) - 64'd1)) != 64'd0};
        if (x[31] == y[31])
        begin
            mag = big + lit;
            s   = x[31];
        end
        else if (big >= lit)
        begin
            mag = big - lit;
            s   = x[31];
        end
        else
        begin
            mag = lit - big;
            s   = y[31];
        end
        // Exact cancellation of unlike signs gives +0 under nearest even.
        if (mag == 64'd0 && x[31] != y[31])
            return 32'd0;
        return fp_round_pack(s, mag, ex - 150 - 39);
    endfunction

    function automatic int dim_used(input logic [4:0] d);
        return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // Scale C by beta, then accumulate alpha*A*B in row, inner, column order.
    function automatic void gemm_update();
        int m;
        int n;
        int k;
        logic [31:0] t;
        m = dim_used(dim_m);
        n = dim_used(dim_n);
        k = dim_used(dim_k);
        for (int i = 0; i < m; i++)
            for (int j = 0; j < n; j++)
                c_mem[i*MAX_DIM+j] = fp_mul(c_mem[i*MAX_DIM+j], beta_f);
        for (int i = 0; i < m; i++)
            for (int kk = 0; kk < k; kk++)
            begin
                t = fp_mul(alpha_f, a_mem[i*MAX_DIM+kk]);
                for (int j = 0; j < n; j++)
                    c_mem[i*MAX_DIM+j] = fp_add(c_mem[i*MAX_DIM+j],
                                                fp_mul(t, b_mem[kk*MAX_DIM+j]));
            end
    endfunction

    // Apply one accepted request to the shadow copy; queue what it owes.
    function automatic void apply_request(input gemm_req_t q);
        int        idx;
        gemm_res_t res;
        idx = int'(q.r) * MAX_DIM + int'(q.c);
        case (q.op)
            CMD_LOAD_A: a_mem[idx] = q.v;
            CMD_LOAD_B: b_mem[idx] = q.v;
            CMD_LOAD_C: c_mem[idx] = q.v;
            CMD_COMPUTE:
            begin
                gemm_update();
                res.k = KIND_DONE;
                res.d = 32'd0;
                owed_q.push_back(res);
            end
            CMD_READ_C:
            begin
                res.k = KIND_READ;
                res.d = c_mem[idx];
                owed_q.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next queued request, hold it while busy, and
    // idle at random according to idle_pct.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        gemm_req_t q;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                q.op = cmd;
                q.r  = row;
                q.c  = col;
                q.v  = value;
                apply_request(q);
            end
            // A request still waiting on busy stays exactly as it is.
            if (!start || !busy)
            begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    q = req_q.pop_front();
                    start <= 1'b1;
                    cmd   <= q.op;
                    row   <= q.r;
                    col   <= q.c;
                    value <= q.v;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        gemm_res_t want;
        if (rst_n && strobe)
        begin
            if (owed_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: kind=%0d data=%08h", kind, data);
            end
            else
            begin
                want = owed_q.pop_front();
                if (kind !== want.k || data !== want.d)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result mismatch: expected kind=%0d data=%08h, got kind=%0d data=%08h",
                                 want.k, want.d, kind, data);
                end
            end
        end
    end

    // Mostly moderate magnitudes, with zeros, infinities, NaNs, subnormals and
    // the largest finite values mixed in.
    function automatic logic [31:0] pick_float();
        logic s;
        s = 1'($urandom);
        case ($urandom_range(0, 19))
            0: return {s, 31'd0};
            1: return {s, 8'hFF, 23'd0};
            2: return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return {s, 8'h00, 23'($urandom)};
            4: return {s, 8'hFE, 23'h7F_FFFF};
            default: return {s, 8'($urandom_range(115, 139)), 23'($urandom)};
        endcase
    endfunction

    task automatic push_req(input logic [2:0] op, input logic [3:0] r, input logic [3:0] c,
                            input logic [31:0] v);
        gemm_req_t q;
        q.op = op;
        q.r  = r;
        q.c  = c;
        q.v  = v;
        req_q.push_back(q);
    endtask

    // Hold off until every request is taken and every result has come back,
    // then give the block a short margin to finish any trailing work.
    task automatic drain();
        while (req_q.size() != 0 || start || owed_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        case (idx)
            CFG_ROWS_M:  dim_m = d[4:0];
            CFG_COLS_N:  dim_n = d[4:0];
            CFG_INNER_K: dim_k = d[4:0];
            CFG_ALPHA:   alpha_f = d;
            CFG_BETA:    beta_f = d;
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_dim(input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'd0;
        if (r < 12)
            return 32'($urandom_range(17, 31)) | 32'({$urandom, 5'd0});
        return 32'($urandom_range(1, hi)) | 32'({$urandom, 5'd0});
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Fill all three stores so no compute or read can touch an unwritten
        // element, whatever the dimensions become later.
        for (int i = 0; i < DEPTH; i++)
        begin
            push_req(CMD_LOAD_A, 4'(i / MAX_DIM), 4'(i % MAX_DIM), pick_float());
            push_req(CMD_LOAD_B, 4'(i / MAX_DIM), 4'(i % MAX_DIM), pick_float());
            push_req(CMD_LOAD_C, 4'(i / MAX_DIM), 4'(i % MAX_DIM), pick_float());
        end
        drain();

        // Directed: full-size compute on reset registers, corner elements,
        // extreme values, and the unused command codes.
        push_req(CMD_COMPUTE, 4'd0, 4'd0, 32'd0);
        push_req(CMD_READ_C, 4'd0, 4'd0, 32'd0);
        push_req(CMD_READ_C, 4'd15, 4'd15, 32'd0);
        push_req(CMD_LOAD_C, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_req(CMD_READ_C, 4'd15, 4'd15, 32'd0);
        push_req(CMD_LOAD_C, 4'd0, 4'd15, 32'd0);
        push_req(CMD_READ_C, 4'd0, 4'd15, 32'd0);
        push_req(CMD_LOAD_C, 4'd15, 4'd0, 32'h8000_0000);
        push_req(CMD_READ_C, 4'd15, 4'd0, 32'd0);
        push_req(3'd5, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_req(3'd6, 4'd0, 4'd0, 32'd0);
        push_req(3'd7, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_req(CMD_LOAD_A, 4'd1, 4'd0, 32'h7F80_0000);
        push_req(CMD_LOAD_B, 4'd0, 4'd1, 32'h0000_0001);
        push_req(CMD_LOAD_A, 4'd0, 4'd0, 32'h0000_0001);
        drain();

        // Zero rows: nothing moves, yet the done result still comes.
        reg_write(CFG_ROWS_M, 32'd0);
        reg_write(CFG_BETA, 32'hFFFF_FFFF);
        reg_write(3'd7, 32'hFFFF_FFFF);
        push_req(CMD_COMPUTE, 4'd0, 4'd0, 32'd0);
        push_req(CMD_READ_C, 4'd0, 4'd0, 32'd0);
        drain();

        // Every dimension above the store size saturates, with extreme scales.
        reg_write(CFG_ROWS_M, 32'hFFFF_FFFF);
        reg_write(CFG_COLS_N, 32'h0000_001F);
        reg_write(CFG_INNER_K, 32'h0000_0011);
        reg_write(CFG_ALPHA, 32'h0000_0001);
        reg_write(CFG_BETA, 32'h3F00_0000);
        push_req(CMD_COMPUTE, 4'd0, 4'd0, 32'd0);
        push_req(CMD_READ_C, 4'd7, 4'd9, 32'd0);
        push_req(CMD_READ_C, 4'd15, 4'd15, 32'd0);
        drain();

        // Random phases: fresh registers each time, then a mix that favours
        // reload-compute-readback runs over small blocks.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 46;
                2: idle_pct = 0;
                default: idle_pct = 36;
            endcase
            reg_write(CFG_ROWS_M, pick_dim(5));
            reg_write(CFG_COLS_N, pick_dim(5));
            reg_write(CFG_INNER_K, pick_dim(6));
            reg_write(CFG_ALPHA, ($urandom_range(0, 3) == 0) ? pick_float()
                                 : {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)});
            reg_write(CFG_BETA, ($urandom_range(0, 3) == 0) ? pick_float()
                                : {1'($urandom), 8'($urandom_range(124, 128)), 23'($urandom)});
            for (int n = 0; n < 70; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 9)
                    push_req(CMD_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
                else if (r < 13)
                    push_req(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), $urandom);
                else if (r < 45)
                    push_req(CMD_READ_C, 4'($urandom_range(0, 5)), 4'($urandom_range(0, 5)),
                             $urandom);
                else if (r < 55)
                    push_req(CMD_READ_C, 4'($urandom), 4'($urandom), $urandom);
                else if (r < 85)
                    push_req(3'($urandom_range(0, 2)), 4'($urandom_range(0, 6)),
                             4'($urandom_range(0, 6)), pick_float());
                else
                    push_req(3'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                             pick_float());
            end
            drain();
        end

        if (n_bad == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin : watchdog
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
